// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the cache block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SALC_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SALC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/salc_pkg.sv =====
// Package of shared constants, codes and control types for the LRU cache simulator.
`timescale 1ns / 1ps

package salc_pkg;

	// Default sizing of the cache storage.
	localparam int DEF_MAX_SET_BITS = 6;
	localparam int DEF_MAX_WAYS     = 8;
	localparam int DEF_ADDR_WIDTH   = 64;

	// Fixed field widths.
	localparam int ADDR_PORT_W = 64;
	localparam int CNT_W       = 32;
	localparam int FUNC_W      = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 6;
	localparam int SHAMT_W     = 7;

	// Access kinds carried by the func field.
	localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_MODIFY = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FETCH  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

	// Outcome of one access.
	typedef enum logic [1:0] {
		OUTCOME_HIT   = 2'd0,
		OUTCOME_FILL  = 2'd1,
		OUTCOME_EVICT = 2'd2
	} outcome_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic clear;
		logic read;
		logic update;
		logic last;
	} salc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_done;
	} salc_status_t;

endpackage

// ===== rtl/salc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module salc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/salc_ctrl.sv =====
// Controller state machine that sequences the clearing pass and each cache access.
`timescale 1ns / 1ps

module salc_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [salc_pkg::FUNC_W-1:0] func,
	input  salc_pkg::salc_status_t      status,
	output logic                        busy,
	output salc_pkg::salc_cmd_t         cmd
);
	import salc_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_READ   = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   second_q;
	logic   second_d;
	logic   accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Next state and command decode.
	always_comb begin
		state_d     = state_q;
		second_d    = second_q;
		cmd         = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					unique case (func)
						FUNC_LOAD: begin
							state_d  = ST_READ;
							second_d = 1'b0;
						end
						FUNC_MODIFY: begin
							state_d  = ST_READ;
							second_d = 1'b1;
						end
						FUNC_FETCH: begin
							state_d = ST_IDLE;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				cmd.last   = !second_q;
				if (second_q) begin
					second_d = 1'b0;
					state_d  = ST_READ;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
		end
	end

endmodule

// ===== rtl/salc_dp.sv =====
// Datapath: configuration, set and tag extraction, set storage, LRU update and counters.
`timescale 1ns / 1ps

module salc_dp #(
	parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
	parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS,
	parameter int ADDR_WIDTH   = salc_pkg::DEF_ADDR_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [salc_pkg::ADDR_PORT_W-1:0] address,
	input  salc_pkg::salc_cmd_t             cmd,
	output salc_pkg::salc_status_t          status,
	output logic                            done,
	output logic [1:0]                      outcome,
	output logic [salc_pkg::CNT_W-1:0]      hit_total,
	output logic [salc_pkg::CNT_W-1:0]      miss_total,
	output logic [salc_pkg::CNT_W-1:0]      evict_total,
	output logic                            last_of_item
);
	import salc_pkg::*;

	localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int SB_W     = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;
	localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAY_W    = RANK_W;
	localparam int META_W   = MAX_WAYS * (1 + RANK_W);
	localparam int TROW_W   = MAX_WAYS * ADDR_WIDTH;
	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

	// Configuration registers.
	logic [2:0] set_bits_q;
	logic [5:0] block_bits_q;
	logic [3:0] ways_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= 3'd0;
			block_bits_q <= 6'd0;
			ways_q       <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SET_BITS:   set_bits_q   <= cfg_data[2:0];
				REG_BLOCK_BITS: block_bits_q <= cfg_data[5:0];
				REG_WAYS:       ways_q       <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Captured address of the current transaction.
	logic [ADDR_WIDTH-1:0] addr_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q <= address[ADDR_WIDTH-1:0];
		end
	end

	// Set index and tag of the captured address.
	logic [SB_W-1:0]    sb_eff;
	logic [SHAMT_W-1:0] tag_shamt;
	logic [SET_W:0]     set_mask_wide;
	logic [SET_W-1:0]   set_idx;

	always_comb begin
		if (int'(set_bits_q) > MAX_SET_BITS) begin
			sb_eff = SB_W'(MAX_SET_BITS);
		end else begin
			sb_eff = SB_W'(set_bits_q);
		end
		tag_shamt     = SHAMT_W'(sb_eff) + SHAMT_W'(block_bits_q);
		set_mask_wide = ((SET_W + 1)'(1) << sb_eff) - (SET_W + 1)'(1);
		set_idx       = SET_W'(addr_q >> block_bits_q) & set_mask_wide[SET_W-1:0];
	end

	// Set and tag held for the update cycle.
	logic [SET_W-1:0]      set_s1;
	logic [ADDR_WIDTH-1:0] tag_s1;

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			set_s1 <= set_idx;
			tag_s1 <= addr_q >> tag_shamt;
		end
	end

	// Clearing pass counter over the recency and valid store.
	logic [SET_W-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear) begin
			clr_cnt_q <= clr_cnt_q + SET_W'(1);
		end
	end

	assign status.clr_done = (clr_cnt_q == SET_W'(NUM_SETS - 1));

	// Set storage: valid bits with ranks, and tags, one row per set.
	logic [META_W-1:0] meta_rd;
	logic [META_W-1:0] meta_nx;
	logic [META_W-1:0] meta_wdata;
	logic [SET_W-1:0]  meta_waddr;
	logic              meta_we;
	logic [TROW_W-1:0] tag_rd;
	logic [TROW_W-1:0] tag_nx;
	logic              tag_we;

	assign meta_we    = cmd.clear || cmd.update;
	assign meta_waddr = cmd.clear ? clr_cnt_q : set_s1;
	assign meta_wdata = cmd.clear ? '0 : meta_nx;

	salc_ram #(
		.WIDTH (META_W),
		.DEPTH (NUM_SETS),
		.AW    (SET_W)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.re    (cmd.read),
		.raddr (set_idx),
		.rdata (meta_rd)
	);

	salc_ram #(
		.WIDTH (TROW_W),
		.DEPTH (NUM_SETS),
		.AW    (SET_W)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (set_s1),
		.wdata (tag_nx),
		.re    (cmd.read),
		.raddr (set_idx),
		.rdata (tag_rd)
	);

	// Lookup, victim choice and recency update over the ways of the set.
	logic [MAX_WAYS-1:0] in_use;
	logic [MAX_WAYS-1:0] valid_cur;
	logic [MAX_WAYS-1:0] match;
	logic [RANK_W-1:0]   rank_cur [MAX_WAYS];
	logic [RANK_W-1:0]   rank_nx  [MAX_WAYS];
	logic [MAX_WAYS-1:0] valid_nx;
	logic                any_hit;
	logic                any_empty;
	logic [WAY_W-1:0]    hit_way;
	logic [WAY_W-1:0]    empty_way;
	logic [WAY_W-1:0]    evict_way;
	logic [WAY_W-1:0]    pick;
	logic [RANK_W-1:0]   best_rank;
	logic [RANK_W-1:0]   pick_rank;
	outcome_t            outcome_d;

	always_comb begin
		any_hit   = 1'b0;
		any_empty = 1'b0;
		hit_way   = '0;
		empty_way = '0;
		evict_way = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			in_use[w]    = (w == 0) || (int'(ways_q) > w);
			valid_cur[w] = meta_rd[w];
			rank_cur[w]  = meta_rd[MAX_WAYS + w*RANK_W +: RANK_W];
			match[w]     = in_use[w] && valid_cur[w] &&
				(tag_rd[w*ADDR_WIDTH +: ADDR_WIDTH] == tag_s1);
		end
		// Lowest matching way wins.
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				any_hit = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
		// Highest empty way is filled.
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (in_use[w] && !valid_cur[w]) begin
				any_empty = 1'b1;
				empty_way = WAY_W'(w);
			end
		end
		// Oldest way is evicted, the lowest index on a tie.
		best_rank = rank_cur[0];
		for (int w = 1; w < MAX_WAYS; w++) begin
			if (in_use[w] && (rank_cur[w] > best_rank)) begin
				best_rank = rank_cur[w];
				evict_way = WAY_W'(w);
			end
		end
		if (any_hit) begin
			outcome_d = OUTCOME_HIT;
			pick      = hit_way;
		end else if (any_empty) begin
			outcome_d = OUTCOME_FILL;
			pick      = empty_way;
		end else begin
			outcome_d = OUTCOME_EVICT;
			pick      = evict_way;
		end
		pick_rank = rank_cur[pick];
		// New ranks and valid bits.
		for (int w = 0; w < MAX_WAYS; w++) begin
			valid_nx[w] = valid_cur[w];
			rank_nx[w]  = rank_cur[w];
			if (WAY_W'(w) == pick) begin
				valid_nx[w] = 1'b1;
				rank_nx[w]  = '0;
			end else if (in_use[w] && valid_cur[w]) begin
				if (outcome_d == OUTCOME_FILL) begin
					if (rank_cur[w] != RANK_MAX) begin
						rank_nx[w] = rank_cur[w] + RANK_W'(1);
					end
				end else if (rank_cur[w] < pick_rank) begin
					rank_nx[w] = rank_cur[w] + RANK_W'(1);
				end
			end
		end
		meta_nx[MAX_WAYS-1:0] = valid_nx;
		tag_nx                = tag_rd;
		for (int w = 0; w < MAX_WAYS; w++) begin
			meta_nx[MAX_WAYS + w*RANK_W +: RANK_W] = rank_nx[w];
			if (WAY_W'(w) == pick) begin
				tag_nx[w*ADDR_WIDTH +: ADDR_WIDTH] = tag_s1;
			end
		end
	end

	assign tag_we = cmd.update && !any_hit;

	// Running counts, saturating at all ones.
	logic [CNT_W-1:0] hit_cnt_q;
	logic [CNT_W-1:0] miss_cnt_q;
	logic [CNT_W-1:0] evict_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
		end else if (cmd.update) begin
			if (outcome_d == OUTCOME_HIT) begin
				if (hit_cnt_q != '1) begin
					hit_cnt_q <= hit_cnt_q + CNT_W'(1);
				end
			end else begin
				if (miss_cnt_q != '1) begin
					miss_cnt_q <= miss_cnt_q + CNT_W'(1);
				end
				if ((outcome_d == OUTCOME_EVICT) && (evict_cnt_q != '1)) begin
					evict_cnt_q <= evict_cnt_q + CNT_W'(1);
				end
			end
		end
	end

	// Result strobe, shown for one cycle after the update, and its payload.
	logic     done_q;
	outcome_t outcome_q;
	logic     last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.update;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			outcome_q <= outcome_d;
			last_q    <= cmd.last;
		end
	end

	assign done         = done_q;
	assign outcome      = outcome_q;
	assign last_of_item = last_q;
	assign hit_total    = hit_cnt_q;
	assign miss_total   = miss_cnt_q;
	assign evict_total  = evict_cnt_q;

endmodule

// ===== rtl/set_assoc_lru_cache_sim_top.sv =====
// Top level of the tag-only set-associative cache simulator with true LRU replacement.
// A transaction is accepted when start is high and busy is low. A load gives one
// result, a modify gives two results, and an instruction fetch (or the unused func
// code) is taken with no result and busy staying low. Each access is one registered
// read of the set row from the set storage followed by lookup and write-back. Each
// result appears in the cycle after its update, marked by done for exactly one cycle;
// the receiver cannot hold it off, so it must take it then. After reset, busy stays
// high while the valid and recency store is cleared one set per cycle; configuration
// writes are taken at any time.
`timescale 1ns / 1ps

module set_assoc_lru_cache_sim_top #(
	parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
	parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS,
	parameter int ADDR_WIDTH   = salc_pkg::DEF_ADDR_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             start,
	output logic                             busy,
	input  logic [salc_pkg::FUNC_W-1:0]      func,
	input  logic [salc_pkg::ADDR_PORT_W-1:0] address,
	output logic                             done,
	output logic [1:0]                       outcome,
	output logic [salc_pkg::CNT_W-1:0]       hit_total,
	output logic [salc_pkg::CNT_W-1:0]       miss_total,
	output logic [salc_pkg::CNT_W-1:0]       evict_total,
	output logic                             last_of_item
);
	import salc_pkg::*;

	salc_cmd_t    cmd;
	salc_status_t status;

	// Sequencer.
	salc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Storage, lookup and counters.
	salc_dp #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS),
		.ADDR_WIDTH   (ADDR_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.address      (address),
		.cmd          (cmd),
		.status       (status),
		.done         (done),
		.outcome      (outcome),
		.hit_total    (hit_total),
		.miss_total   (miss_total),
		.evict_total  (evict_total),
		.last_of_item (last_of_item)
	);

endmodule

// ===== rtl/salc_chk.sv =====
// Port-level checker for the cache simulator top level, with its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module salc_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic [salc_pkg::FUNC_W-1:0] func,
	input logic                        done,
	input logic [1:0]                  outcome,
	input logic [salc_pkg::CNT_W-1:0]  hit_total,
	input logic [salc_pkg::CNT_W-1:0]  miss_total,
	input logic [salc_pkg::CNT_W-1:0]  evict_total,
	input logic                        last_of_item
);
	import salc_pkg::*;

	// An accepted load or modify keeps the block busy in the next cycle.
	`SALC_ASSERT_NEXT(a_access_busy, start && !busy && (func == FUNC_LOAD || func == FUNC_MODIFY), busy, "access transaction did not raise busy")

	// Results never come in adjacent cycles.
	`SALC_ASSERT_NEXT(a_done_gap, done, !done, "two results in adjacent cycles")

	// After the first result of a modify, the second access is still pending.
	`SALC_ASSERT_NOW(a_first_busy, done && !last_of_item, busy, "first result of a modify without pending access")

	// A hit bumps the hit count by one unless it has saturated.
	`SALC_ASSERT_NOW(a_hit_count, done && outcome == OUTCOME_HIT, hit_total == $past(hit_total) + 32'd1 || $past(hit_total) == 32'hFFFF_FFFF, "hit count did not follow a hit")

	// A hit leaves the miss and eviction counts alone.
	`SALC_ASSERT_NOW(a_hit_other, done && outcome == OUTCOME_HIT, miss_total == $past(miss_total) && evict_total == $past(evict_total), "miss or eviction count moved on a hit")

endmodule

bind set_assoc_lru_cache_sim_top salc_chk u_chk (.*);

// ===== dv/set_assoc_lru_cache_sim_top_tb.sv =====
// Self-checking testbench for the set-associative LRU cache simulator top level.
`timescale 1ns / 1ps

module set_assoc_lru_cache_sim_top_tb;

	import salc_pkg::*;

	localparam int MAX_SET_BITS = DEF_MAX_SET_BITS;
	localparam int MAX_WAYS     = DEF_MAX_WAYS;
	localparam int NUM_LINES    = (1 << MAX_SET_BITS) * MAX_WAYS;
	localparam int HOT_LINES    = 16;

	// The func code that the block must ignore, and the register index that is not in use.
	localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONE    = 2'd3;

	// One expected result of an access.
	typedef struct {
		outcome_t          kind;
		logic [CNT_W-1:0]  hits;
		logic [CNT_W-1:0]  misses;
		logic [CNT_W-1:0]  evictions;
		logic              last;
	} access_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   start;
	logic                   busy;
	logic [FUNC_W-1:0]      func;
	logic [ADDR_PORT_W-1:0] address;
	logic                   done;
	logic [1:0]             outcome;
	logic [CNT_W-1:0]       hit_total;
	logic [CNT_W-1:0]       miss_total;
	logic [CNT_W-1:0]       evict_total;
	logic                   last_of_item;

	// Shadow copy of the cache contents, the counts and the geometry registers.
	bit               line_ok [NUM_LINES];
	logic [63:0]      line_tags [NUM_LINES];
	int               recency [NUM_LINES];
	logic [CNT_W-1:0] hit_cnt;
	logic [CNT_W-1:0] miss_cnt;
	logic [CNT_W-1:0] evict_cnt;
	logic [2:0]       geo_set_bits;
	logic [5:0]       geo_block_bits;
	logic [3:0]       geo_ways;

	access_result_t pending_results [$];
	logic [63:0]    hot_lines [HOT_LINES];
	int             idle_pct;
	int             mismatch_count;

	set_assoc_lru_cache_sim_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.address      (address),
		.done         (done),
		.outcome      (outcome),
		.hit_total    (hit_total),
		.miss_total   (miss_total),
		.evict_total  (evict_total),
		.last_of_item (last_of_item)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Out-of-range geometry is clamped before use.
	function automatic int eff_set_bits();
		return (geo_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(geo_set_bits);
	endfunction

	function automatic int eff_ways();
		if (geo_ways == 0)
			return 1;
		return (geo_ways > MAX_WAYS) ? MAX_WAYS : int'(geo_ways);
	endfunction

	// Builds a line address from a tag and a set under the current geometry.
	function automatic logic [63:0] make_addr(logic [63:0] tag, int set_no);
		int sb;
		sb = eff_set_bits();
		return (tag << (sb + geo_block_bits)) | (64'(set_no) << geo_block_bits);
	endfunction

	// One lookup with LRU update; shifts of 64 or more give zero in SystemVerilog.
	function automatic outcome_t cache_access(logic [63:0] addr);
		int          sb;
		int          nw;
		int          base;
		int          hit_way;
		int          empty_way;
		int          pick;
		logic [63:0] set_idx;
		logic [63:0] tag;
		outcome_t    kind;
		sb = eff_set_bits();
		nw = eff_ways();
		set_idx = (addr >> geo_block_bits) & ((64'd1 << sb) - 64'd1);
		tag = addr >> (sb + geo_block_bits);
		base = int'(set_idx) * MAX_WAYS;
		hit_way = -1;
		empty_way = -1;
		for (int w = 0; w < nw; w++) begin
			if (line_ok[base + w]) begin
				if (hit_way < 0 && line_tags[base + w] == tag)
					hit_way = w;
			end else begin
				empty_way = w;
			end
		end

		// A miss with a free way fills it and ages every valid way in use, up to the top rank.
		if (hit_way < 0 && empty_way >= 0) begin
			for (int w = 0; w < nw; w++)
				if (line_ok[base + w] && recency[base + w] < MAX_WAYS - 1)
					recency[base + w]++;
			line_ok[base + empty_way] = 1'b1;
			line_tags[base + empty_way] = tag;
			recency[base + empty_way] = 0;
			if (miss_cnt != '1)
				miss_cnt++;
			return OUTCOME_FILL;
		end

		if (hit_way >= 0) begin
			pick = hit_way;
			if (hit_cnt != '1)
				hit_cnt++;
			kind = OUTCOME_HIT;
		end else begin
			// The oldest way goes; the lowest index wins a tie.
			pick = 0;
			for (int w = 1; w < nw; w++)
				if (recency[base + w] > recency[base + pick])
					pick = w;
			line_tags[base + pick] = tag;
			if (miss_cnt != '1)
				miss_cnt++;
			if (evict_cnt != '1)
				evict_cnt++;
			kind = OUTCOME_EVICT;
		end
		for (int w = 0; w < nw; w++)
			if (w != pick && line_ok[base + w] && recency[base + w] < recency[base + pick])
				recency[base + w]++;
		recency[base + pick] = 0;
		return kind;
	endfunction

	// Queues the results that one accepted transaction must produce.
	task automatic predict_item(logic [FUNC_W-1:0] f, logic [63:0] a);
		access_result_t r;
		int             n;
		n = (f == FUNC_LOAD) ? 1 : ((f == FUNC_MODIFY) ? 2 : 0);
		for (int k = 0; k < n; k++) begin
			r.kind = cache_access(a);
			r.hits = hit_cnt;
			r.misses = miss_cnt;
			r.evictions = evict_cnt;
			r.last = (k == n - 1);
			pending_results.push_back(r);
		end
	endtask

	// Sends one transaction, holding start until it is taken, then idles at random.
	task automatic send_item(logic [FUNC_W-1:0] f, logic [63:0] a);
		start <= 1'b1;
		func <= f;
		address <= a;
		do
			@(posedge clk);
		while (busy);
		predict_item(f, a);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Stops sending and waits for every outstanding result, with a limit.
	task automatic wait_drained();
		int guard;
		guard = 0;
		start <= 1'b0;
		do begin
			@(posedge clk);
			guard++;
		end while (pending_results.size() != 0 && guard < 4000);
	endtask

	// Drives one register write; the caller lowers the write enable.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_SET_BITS:   geo_set_bits = data[2:0];
			REG_BLOCK_BITS: geo_block_bits = data[5:0];
			REG_WAYS:       geo_ways = data[3:0];
			default:        ;
		endcase
	endtask

	// Reconfigures the geometry once the block is idle; unused upper data bits are random.
	task automatic set_geometry(int sb, int bb, int nw);
		wait_drained();
		repeat (6) @(posedge clk);
		write_reg(REG_NONE, 6'($urandom_range(0, 63)));
		write_reg(REG_SET_BITS, {3'($urandom_range(0, 7)), 3'(sb)});
		write_reg(REG_BLOCK_BITS, 6'(bb));
		write_reg(REG_WAYS, {2'($urandom_range(0, 3)), 4'(nw)});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Direct-mapped single set: fill, hit, eviction, modify, fetch and the unused code.
	task automatic test_direct_mapped();
		idle_pct = 0;
		set_geometry(0, 0, 1);
		send_item(FUNC_LOAD, 64'd0);
		send_item(FUNC_LOAD, 64'd0);
		send_item(FUNC_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(FUNC_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(FUNC_FETCH, 64'd0);
		send_item(FUNC_UNUSED, 64'hA5A5_5A5A_A5A5_5A5A);
		send_item(FUNC_MODIFY, 64'h8000_0000_0000_0000);
	endtask

	// Four ways in one set: fills from the top way down, then true LRU eviction order.
	task automatic test_lru_order();
		set_geometry(2, 4, 4);
		for (int t = 10; t < 14; t++)
			send_item(FUNC_LOAD, make_addr(64'(t), 1));
		send_item(FUNC_LOAD, make_addr(64'd10, 1));
		send_item(FUNC_LOAD, make_addr(64'd14, 1));
		send_item(FUNC_LOAD, make_addr(64'd11, 1));
	endtask

	// A way left out of use keeps a stale rank, so two ways tie for eviction.
	task automatic test_eviction_tie();
		send_item(FUNC_LOAD, make_addr(64'd20, 2));
		set_geometry(2, 4, 2);
		send_item(FUNC_LOAD, make_addr(64'd21, 2));
		set_geometry(2, 4, 4);
		send_item(FUNC_LOAD, make_addr(64'd22, 2));
		send_item(FUNC_LOAD, make_addr(64'd23, 2));
		send_item(FUNC_LOAD, make_addr(64'd24, 2));
	endtask

	// Shrinking the associativity lets the same tag sit in two ways of a set.
	task automatic test_duplicate_tags();
		set_geometry(2, 4, 2);
		send_item(FUNC_LOAD, make_addr(64'd30, 3));
		set_geometry(2, 4, 1);
		send_item(FUNC_LOAD, make_addr(64'd30, 3));
		set_geometry(2, 4, 2);
		send_item(FUNC_LOAD, make_addr(64'd30, 3));
		send_item(FUNC_LOAD, make_addr(64'd31, 3));
		send_item(FUNC_LOAD, make_addr(64'd30, 3));
	endtask

	// Clamped set bits and ways, and a tag shift past the address width.
	task automatic test_wide_shift();
		set_geometry(7, 63, 15);
		send_item(FUNC_LOAD, 64'h8000_0000_0000_0000);
		send_item(FUNC_LOAD, 64'd0);
		send_item(FUNC_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	// Picks an address: mostly reused lines, some forced conflicts, some noise.
	function automatic logic [63:0] pick_address();
		int          sel;
		logic [63:0] offset;
		logic [63:0] line;
		sel = $urandom_range(0, 99);
		offset = {$urandom(), $urandom()} & ((64'd1 << geo_block_bits) - 64'd1);
		if (sel < 60)
			line = hot_lines[$urandom_range(0, HOT_LINES - 1)];
		else if (sel < 85)
			line = make_addr(64'($urandom_range(0, eff_ways() + 2)),
				$urandom_range(0, (1 << eff_set_bits()) - 1));
		else
			return {$urandom(), $urandom()};
		return line ^ offset;
	endfunction

	// One random phase under a fixed geometry and sender idle rate.
	task automatic run_traffic(int sb, int bb, int nw, int pct, int n_items);
		int                counted;
		int                sel;
		logic [FUNC_W-1:0] f;
		set_geometry(sb, bb, nw);
		idle_pct = pct;
		for (int i = 0; i < HOT_LINES; i++)
			hot_lines[i] = {$urandom(), $urandom()};
		counted = 0;
		while (counted < n_items) begin
			sel = $urandom_range(0, 99);
			if (sel < 50)
				f = FUNC_LOAD;
			else if (sel < 85)
				f = FUNC_MODIFY;
			else if (sel < 95)
				f = FUNC_FETCH;
			else
				f = FUNC_UNUSED;
			send_item(f, pick_address());
			counted++;
			// Now and then the sender holds off until the block has fully drained.
			if (counted % 120 == 119 && f != FUNC_FETCH && f != FUNC_UNUSED)
				wait_drained();
		end
	endtask

	// Fixed phases covering the geometry extremes, then randomly chosen ones.
	task automatic test_random_traffic();
		int pcts [3];
		pcts = '{0, 31, 67};
		run_traffic(0, 0, 1, 0, 150);
		run_traffic(6, 32, 8, 67, 250);
		run_traffic(3, 5, 4, 0, 250);
		run_traffic(2, 6, 2, 31, 250);
		run_traffic(7, 63, 15, 31, 150);
		run_traffic(1, 12, 0, 67, 150);
		for (int p = 0; p < 5; p++)
			run_traffic($urandom_range(0, 7), $urandom_range(0, 40), $urandom_range(0, 15),
				pcts[$urandom_range(0, 2)], 90);
	endtask

	// Each result strobe is matched against the oldest expectation.
	always @(posedge clk) begin
		access_result_t head;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no expectation pending");
				mismatch_count++;
			end else begin
				head = pending_results.pop_front();
				if (outcome !== head.kind) begin
					$error("outcome: expected %0d, got %0d", head.kind, outcome);
					mismatch_count++;
				end
				if (hit_total !== head.hits) begin
					$error("hit_total: expected %0d, got %0d", head.hits, hit_total);
					mismatch_count++;
				end
				if (miss_total !== head.misses) begin
					$error("miss_total: expected %0d, got %0d", head.misses, miss_total);
					mismatch_count++;
				end
				if (evict_total !== head.evictions) begin
					$error("evict_total: expected %0d, got %0d", head.evictions, evict_total);
					mismatch_count++;
				end
				if (last_of_item !== head.last) begin
					$error("last_of_item: expected %0d, got %0d", head.last, last_of_item);
					mismatch_count++;
				end
			end
		end
	end

	// Main sequence: reset once, then each test in turn.
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SET_BITS;
		cfg_data <= '0;
		start <= 1'b0;
		func <= FUNC_LOAD;
		address <= '0;
		mismatch_count = 0;
		idle_pct = 0;
		hit_cnt = '0;
		miss_cnt = '0;
		evict_cnt = '0;
		geo_set_bits = 3'd0;
		geo_block_bits = 6'd0;
		geo_ways = 4'd1;
		for (int i = 0; i < NUM_LINES; i++) begin
			line_ok[i] = 1'b0;
			line_tags[i] = '0;
			recency[i] = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_direct_mapped();
		test_lru_order();
		test_eviction_tie();
		test_duplicate_tags();
		test_wide_shift();
		test_random_traffic();

		wait_drained();
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("set_assoc_lru_cache_sim_top: match");
		else
			$display("set_assoc_lru_cache_sim_top: mismatch");
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#800000;
		$display("set_assoc_lru_cache_sim_top: mismatch");
		$finish;
	end

endmodule

// ===== set_assoc_lru_cache_sim_top.f =====
+incdir+rtl
rtl/salc_pkg.sv
rtl/salc_ram.sv
rtl/salc_ctrl.sv
rtl/salc_dp.sv
rtl/set_assoc_lru_cache_sim_top.sv
rtl/salc_chk.sv
dv/set_assoc_lru_cache_sim_top_tb.sv
